// ----- hdl/rstr_pkg.sv -----
// shared types and constants of the rotor spool-up throttle ramp
package rstr_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_ARM      = 2'd0;
    localparam logic [1:0] CMD_THROTTLE = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    // headspeed levels
    localparam logic [1:0] LVL_NORMAL   = 2'd0;
    localparam logic [1:0] LVL_IDLE_ONE = 2'd1;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SPOOL_SECONDS = 3'd0;
    localparam logic [2:0] REG_GOV_SET_EN    = 3'd1;
    localparam logic [2:0] REG_RPM_NORMAL    = 3'd2;
    localparam logic [2:0] REG_RPM_IDLE_ONE  = 3'd3;
    localparam logic [2:0] REG_RPM_IDLE_TWO  = 3'd4;
    localparam logic [2:0] REG_ESC_MAX_AGE   = 3'd5;

    // throttle pulse width at which the motor is at rest
    localparam logic [10:0] THR_IDLE = 11'd1000;
    localparam logic [10:0] THR_MAX  = 11'd2047;

    typedef struct packed {
        logic [7:0]  spool_seconds;
        logic        governor_set_enable;
        logic [15:0] rpm_target_normal;
        logic [15:0] rpm_target_idle_one;
        logic [15:0] rpm_target_idle_two;
        logic [7:0]  esc_max_age;
    } rstr_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic exec;
    } rstr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } rstr_sts_t;

endpackage

// ----- hdl/rstr_cfg_regs.sv -----
// configuration register file behind the apb-style port
module rstr_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output rstr_pkg::rstr_cfg_t cfg
);
    import rstr_pkg::*;

    rstr_cfg_t cfg_reg;
    rstr_cfg_t cfg_next;
    logic      wr_en;
    logic [2:0] idx;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SPOOL_SECONDS: cfg_next.spool_seconds       = pwdata[7:0];
                REG_GOV_SET_EN:    cfg_next.governor_set_enable = pwdata[0];
                REG_RPM_NORMAL:    cfg_next.rpm_target_normal   = pwdata[15:0];
                REG_RPM_IDLE_ONE:  cfg_next.rpm_target_idle_one = pwdata[15:0];
                REG_RPM_IDLE_TWO:  cfg_next.rpm_target_idle_two = pwdata[15:0];
                REG_ESC_MAX_AGE:   cfg_next.esc_max_age         = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spool_seconds       <= 8'd10;
            cfg_reg.governor_set_enable <= 1'b0;
            cfg_reg.rpm_target_normal   <= 16'd1200;
            cfg_reg.rpm_target_idle_one <= 16'd1400;
            cfg_reg.rpm_target_idle_two <= 16'd1600;
            cfg_reg.esc_max_age         <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_SPOOL_SECONDS: prdata = {24'd0, cfg_reg.spool_seconds};
            REG_GOV_SET_EN:    prdata = {31'd0, cfg_reg.governor_set_enable};
            REG_RPM_NORMAL:    prdata = {16'd0, cfg_reg.rpm_target_normal};
            REG_RPM_IDLE_ONE:  prdata = {16'd0, cfg_reg.rpm_target_idle_one};
            REG_RPM_IDLE_TWO:  prdata = {16'd0, cfg_reg.rpm_target_idle_two};
            REG_ESC_MAX_AGE:   prdata = {24'd0, cfg_reg.esc_max_age};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/rstr_ctrl.sv -----
// sequencing state machine of the ramp unit
module rstr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rstr_pkg::rstr_sts_t sts,
    output rstr_pkg::rstr_cmd_t cmd
);
    import rstr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_EXEC   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.exec      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // update state only once the output slot can take the result
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ----- hdl/rstr_datapath.sv -----
// ramp state, step divider and output register
module rstr_datapath #(
    parameter int TICK_MS   = 200,
    parameter int FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rstr_pkg::rstr_cfg_t cfg,
    input  rstr_pkg::rstr_cmd_t cmd,
    output rstr_pkg::rstr_sts_t sts,
    input  logic [1:0]          in_cmd,
    input  logic [10:0]         in_setpoint,
    input  logic [31:0]         in_now_ms,
    input  logic [1:0]          in_headspeed_level,
    input  logic [15:0]         in_esc_rpm,
    input  logic [7:0]          in_esc_age,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [10:0]         out_throttle,
    output logic                out_fully_spooled
);
    import rstr_pkg::*;

    localparam int VAL_W = 12 + FRAC_BITS;
    localparam int DVD_W = 11 + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [VAL_W-1:0] INIT_VAL = VAL_W'(1000 << FRAC_BITS);
    localparam logic [VAL_W-1:0] HALF_LSB = VAL_W'(1 << (FRAC_BITS - 1));
    localparam logic [31:0]      TICK     = 32'(TICK_MS);

    // latched item
    logic [1:0]  cmd_q_reg;
    logic [10:0] sp_q_reg;
    logic [31:0] now_q_reg;
    logic [1:0]  lvl_q_reg;
    logic [15:0] rpm_q_reg;
    logic [7:0]  age_q_reg;

    // ramp state
    logic             armed_reg,   armed_next;
    logic             ramping_reg, ramping_next;
    logic             done_reg,    done_next;
    logic             settled_reg, settled_next;
    logic [VAL_W-1:0] value_reg,   value_next;
    logic [VAL_W-1:0] step_reg,    step_next;
    logic [31:0]      tick_reg,    tick_next;

    // divider
    logic [10:0]      rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [10:0]      dvsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [11:0]      trial;
    logic [12:0]      diff;

    // output register
    logic             ovalid_reg;
    logic [10:0]      othr_reg;
    logic             ofull_reg;

    logic [10:0]      thr_res;
    logic             full_res;
    logic             gov;
    logic [15:0]      target;
    logic [VAL_W-1:0] sp_fx;
    logic [VAL_W-1:0] value_w;
    logic [VAL_W-1:0] step_w;
    logic [31:0]      tick_w;
    logic [VAL_W-1:0] value_sum;
    logic             bypass;

    function automatic logic [10:0] round_val(input logic [VAL_W-1:0] v);
        logic [VAL_W:0] s;
        s = {1'b0, v} + {1'b0, HALF_LSB};
        if (|s[VAL_W:FRAC_BITS+11])
            return THR_MAX;
        else
            return s[FRAC_BITS+10:FRAC_BITS];
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_q_reg <= in_cmd;
            sp_q_reg  <= in_setpoint;
            now_q_reg <= in_now_ms;
            lvl_q_reg <= in_headspeed_level;
            rpm_q_reg <= in_esc_rpm;
            age_q_reg <= in_esc_age;
        end
    end

    // start-of-ramp step: restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= {sp_q_reg - THR_IDLE, {FRAC_BITS{1'b0}}};
            dvsr_reg <= 11'({cfg.spool_seconds, 2'b00}) + 11'(cfg.spool_seconds);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[12])
            begin
                rem_reg <= diff[10:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[10:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    // governor check
    always_comb
    begin
        case (lvl_q_reg)
            LVL_NORMAL:   target = cfg.rpm_target_normal;
            LVL_IDLE_ONE: target = cfg.rpm_target_idle_one;
            default:      target = cfg.rpm_target_idle_two;
        endcase
    end

    assign gov = cfg.governor_set_enable && (age_q_reg <= cfg.esc_max_age)
                 && (rpm_q_reg >= target);

    assign sp_fx  = {1'b0, sp_q_reg, {FRAC_BITS{1'b0}}};
    assign bypass = !armed_reg || (!ramping_reg && sp_q_reg == THR_IDLE)
                    || (cfg.spool_seconds == 8'd0);

    assign value_w   = ramping_reg ? value_reg : INIT_VAL;
    assign tick_w    = ramping_reg ? tick_reg : 32'd0;
    assign step_w    = ramping_reg ? step_reg
                     : ((sp_q_reg > THR_IDLE) ? VAL_W'(quo_reg) : '0);
    assign value_sum = value_w + step_w;

    always_comb
    begin
        armed_next   = armed_reg;
        ramping_next = ramping_reg;
        done_next    = done_reg;
        settled_next = settled_reg;
        value_next   = value_reg;
        step_next    = step_reg;
        tick_next    = tick_reg;
        thr_res      = 11'd0;
        full_res     = 1'b0;
        case (cmd_q_reg)
            CMD_ARM:
            begin
                value_next   = INIT_VAL;
                armed_next   = 1'b1;
                done_next    = 1'b0;
                settled_next = 1'b0;
            end
            CMD_THROTTLE:
            begin
                if (bypass)
                begin
                    if (cfg.spool_seconds == 8'd0)
                        done_next = 1'b1;
                    thr_res = gov ? round_val(value_reg) : sp_q_reg;
                end
                else
                begin
                    ramping_next = 1'b1;
                    value_next   = value_w;
                    tick_next    = tick_w;
                    step_next    = step_w;
                    if (sp_q_reg == THR_IDLE)
                    begin
                        // abort, ramp value kept
                        ramping_next = 1'b0;
                        thr_res      = sp_q_reg;
                    end
                    else if (sp_fx <= value_w)
                    begin
                        armed_next   = 1'b0;
                        ramping_next = 1'b0;
                        done_next    = 1'b1;
                        value_next   = INIT_VAL;
                        thr_res      = sp_q_reg;
                    end
                    else
                    begin
                        if (now_q_reg >= tick_w)
                        begin
                            value_next = value_sum;
                            tick_next  = now_q_reg + TICK;
                            if (value_sum >= sp_fx || gov)
                            begin
                                armed_next   = 1'b0;
                                ramping_next = 1'b0;
                                done_next    = 1'b1;
                            end
                        end
                        thr_res = round_val(value_next);
                    end
                end
            end
            CMD_QUERY:
            begin
                if (!settled_reg)
                    settled_next = (now_q_reg >= tick_reg);
                full_res = settled_next && done_reg;
            end
            default:
            begin
                thr_res = 11'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            ramping_reg <= 1'b0;
            done_reg    <= 1'b0;
            settled_reg <= 1'b0;
            value_reg   <= INIT_VAL;
            step_reg    <= '0;
            tick_reg    <= 32'd0;
        end
        else if (cmd.exec)
        begin
            armed_reg   <= armed_next;
            ramping_reg <= ramping_next;
            done_reg    <= done_next;
            settled_reg <= settled_next;
            value_reg   <= value_next;
            step_reg    <= step_next;
            tick_reg    <= tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            othr_reg  <= thr_res;
            ofull_reg <= full_res;
        end
    end

    assign sts.need_div = (cmd_q_reg == CMD_THROTTLE) && armed_reg && !ramping_reg
                          && (cfg.spool_seconds != 8'd0) && (sp_q_reg > THR_IDLE);
    assign sts.div_done = (cnt_reg == '0);
    assign sts.out_free = !ovalid_reg || out_ready;

    assign out_valid         = ovalid_reg;
    assign out_throttle      = othr_reg;
    assign out_fully_spooled = ofull_reg;

endmodule

// ----- hdl/rotor_spoolup_throttle_ramp_unit.sv -----
// top level of the rotor spool-up throttle ramp
//
// soft-start throttle ramp for a rotor motor. each input transaction carries a
// command in tuser (arm, throttle, query) and returns exactly one result
// transaction: the throttle to apply for a throttle command, the spooled-up
// flag for a query, zeros otherwise. one transaction is worked at a time.
// arm, query and most throttle transactions pass through accept, decode and
// execute before the input is ready again. the throttle transaction that
// starts a ramp also computes the ramp step (setpoint-1000)/(5*spool_seconds)
// in a restoring divider that yields one quotient bit per cycle, between
// decode and execute. the execute step waits while a previous result is
// still held unaccepted on the output. configuration is to be written over
// the apb-style port only while the block is idle; the block itself does
// not enforce this. pready is always high.
module rotor_spoolup_throttle_ramp_unit #(
    parameter int TICK_MS   = 200,
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // setpoint[10:0], now_ms[42:11], headspeed_level[44:43], esc_rpm[60:45],
    // esc_age[68:61], zero[71:69]
    input  logic [71:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // throttle_out[10:0], fully_spooled[11], zero[15:12]
    output logic [15:0] m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rstr_pkg::*;

    rstr_cfg_t  cfg;
    rstr_cmd_t  cmd;
    rstr_sts_t  sts;
    logic [10:0] throttle_out;
    logic        fully_spooled;

    // no wait states on the register port
    assign pready = 1'b1;

    rstr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // controller: accept, decode, optional divide, execute into output register
    rstr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: item latch, ramp state, step divider, result register
    rstr_datapath #(
        .TICK_MS   (TICK_MS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .sts                (sts),
        .in_cmd             (s_axis_tuser),
        .in_setpoint        (s_axis_tdata[10:0]),
        .in_now_ms          (s_axis_tdata[42:11]),
        .in_headspeed_level (s_axis_tdata[44:43]),
        .in_esc_rpm         (s_axis_tdata[60:45]),
        .in_esc_age         (s_axis_tdata[68:61]),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .out_throttle       (throttle_out),
        .out_fully_spooled  (fully_spooled)
    );

    // pack the result, padding bits tied low
    assign m_axis_tdata = {4'd0, fully_spooled, throttle_out};

endmodule

// ----- hdl/rstr_checker.sv -----
// port-level checks of the ramp unit and their binding
module rstr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one transaction at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after acceptance");

    // a new result appears as the block returns to ready
    a_result_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued while still busy");

    // only one of throttle and query answer can be non-zero
    a_exclusive_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[11] && (m_axis_tdata[10:0] != 11'd0)))
        else $error("throttle and query answer both set");

endmodule

bind rotor_spoolup_throttle_ramp_unit rstr_checker u_rstr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
